// File: src/ket_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed entry table: entry type, text helpers and codes.
// Used by keyed_entry_table and ket_checker.
package ket_pkg;

    localparam int TEXT_BYTES = 15;
    localparam int LOW_W      = 64;
    localparam int HIGH_W     = 56;
    localparam int TEXT_W     = LOW_W + HIGH_W;
    localparam int COLOUR_W   = 32;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int MAXC_W     = 5;

    localparam logic [MODE_W-1:0] MODE_UPSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_KEY = 2'd3;

    typedef logic [TEXT_W-1:0] t_text;

    typedef struct packed {
        logic signed [COLOUR_W-1:0] colour;
        logic [HIGH_W-1:0]          title_high;
        logic [LOW_W-1:0]           title_low;
        logic [HIGH_W-1:0]          key_high;
        logic [LOW_W-1:0]           key_low;
    } t_entry;

    // zero every byte after the first zero byte
    function automatic t_text clip_text(input t_text txt);
        t_text res;
        logic  ended;
        res   = txt;
        ended = 1'b0;
        for (int b = 0; b < TEXT_BYTES; b++) begin
            if (ended) begin
                res[b*8 +: 8] = 8'd0;
            end else if (txt[b*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: src/keyed_entry_table.sv
`timescale 1ns / 1ps
// Keyed entry table: ordered key/title/colour table with upsert, remove and list.
// Depends on ket_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one request item: mode, key,
//   title, colour and list_limit. o_stall is high while a request is in work;
//   one request at a time, the next one taken once its last result is issued.
//   Output channel (o_valid / i_stall) carries result items from a single
//   output register that holds its item while i_stall is high.
//   Upsert and remove give one result; list gives min(count, list_limit)
//   entries with last on the final one, or a single empty result.
// Timing:
//   One shared entry memory port (one read, one write per cycle) and one
//   120-bit key comparator walk the table one entry per cycle, a list walk
//   only while the output is not stalled. Upsert searches, then writes the
//   entry in place or appends it; remove searches, then shifts later entries down.
//   List: entries follow one per cycle while the receiver does not stall.
//   When the receiver stalls, the sequencer waits with the result held.
// Reset: synchronous, clears the entry count and the sequencer; entry
//   contents are not cleared and are never read before written.
module keyed_entry_table
    import ket_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [LOW_W-1:0]           i_key_low,
    input  logic [HIGH_W-1:0]          i_key_high,
    input  logic [LOW_W-1:0]           i_title_low,
    input  logic [HIGH_W-1:0]          i_title_high,
    input  logic signed [COLOUR_W-1:0] i_colour,
    input  logic [MAXC_W-1:0]          i_list_limit,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [CNT_W-1:0]           o_entry_total,
    output logic                       o_entry_valid,
    output logic [LOW_W-1:0]           o_out_key_low,
    output logic [HIGH_W-1:0]          o_out_key_high,
    output logic [LOW_W-1:0]           o_out_title_low,
    output logic [HIGH_W-1:0]          o_out_title_high,
    output logic signed [COLOUR_W-1:0] o_out_colour,
    output logic                       o_last
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CMP_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_LIST   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;

    logic [MODE_W-1:0]   r_mode, n_mode;
    t_text               r_key, n_key;
    t_text               r_title, n_title;
    logic [COLOUR_W-1:0] r_colour, n_colour;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_cmp_valid, n_cmp_valid;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_widx, n_widx;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [STATUS_W-1:0] r_status, n_status;

    t_entry              r_out, n_out;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [CNT_W-1:0]    r_out_total, n_out_total;
    logic                r_out_ev, n_out_ev;
    logic                r_out_last, n_out_last;

    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;
    t_entry              new_entry;
    logic                out_free;
    logic                hit;
    logic                list_last;
    t_text               in_key;
    logic [CNT_W-1:0]    list_n;
    logic [CNT_W-1:0]    idx_inc;

    assign out_free  = !r_out_valid || !i_stall;
    assign hit       = r_cmp_valid && ({r_rd.key_high, r_rd.key_low} == r_key);
    assign idx_inc   = r_idx + 1'b1;
    assign list_last = (idx_inc == r_n);
    assign in_key    = clip_text({i_key_high, i_key_low});
    assign list_n    = (CMP_W'(i_list_limit) < CMP_W'(r_count)) ?
                       CNT_W'(i_list_limit) : r_count;

    always_comb begin
        new_entry.key_low    = r_key[LOW_W-1:0];
        new_entry.key_high   = r_key[TEXT_W-1:LOW_W];
        new_entry.title_low  = r_title[LOW_W-1:0];
        new_entry.title_high = r_title[TEXT_W-1:LOW_W];
        new_entry.colour     = r_colour;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_stall;
        n_mode       = r_mode;
        n_key        = r_key;
        n_title      = r_title;
        n_colour     = r_colour;
        n_idx        = r_idx;
        n_cmp_valid  = r_cmp_valid;
        n_cmp_idx    = r_cmp_idx;
        n_pend       = r_pend;
        n_widx       = r_widx;
        n_n          = r_n;
        n_status     = r_status;
        n_out        = r_out;
        n_out_status = r_out_status;
        n_out_total  = r_out_total;
        n_out_ev     = r_out_ev;
        n_out_last   = r_out_last;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = r_cmp_idx;
        wr_data      = new_entry;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode      = i_mode;
                    n_key       = in_key;
                    n_title     = clip_text({i_title_high, i_title_low});
                    n_colour    = i_colour;
                    n_idx       = '0;
                    n_cmp_valid = 1'b0;
                    n_n         = list_n;
                    n_status    = ST_OK;
                    case (i_mode)
                        MODE_UPSERT: begin
                            if (in_key[7:0] == 8'd0) begin
                                n_status = ST_EMPTY_KEY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        MODE_REMOVE: n_state = S_SEARCH;
                        MODE_LIST: n_state = (list_n == '0) ? S_RESP : S_LIST;
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SEARCH: begin
                rd_addr = r_idx[IDX_W-1:0];
                if (hit) begin
                    if (r_mode == MODE_UPSERT) begin
                        wr_en   = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_idx   = CNT_W'(r_cmp_idx) + 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                end else if (r_idx == r_count) begin
                    n_state = S_RESP;
                    if (r_mode == MODE_REMOVE) begin
                        n_status = ST_NOT_FOUND;
                    end else if (r_count == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_count[IDX_W-1:0];
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_idx[IDX_W-1:0];
                    n_idx       = idx_inc;
                end
            end
            S_SHIFT: begin
                rd_addr = r_idx[IDX_W-1:0];
                wr_en   = r_pend;
                wr_addr = r_widx;
                wr_data = r_rd;
                if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_widx = IDX_W'(r_idx - 1'b1);
                    n_idx  = idx_inc;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - 1'b1;
                        n_state = S_RESP;
                    end
                end
            end
            S_LIST: begin
                rd_addr = r_idx[IDX_W-1:0];
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_rd;
                    n_out_status = ST_OK;
                    n_out_total  = r_count;
                    n_out_ev     = 1'b1;
                    n_out_last   = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        rd_addr = idx_inc[IDX_W-1:0];
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out_status = r_status;
                    n_out_total  = r_count;
                    n_out_ev     = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_title      <= n_title;
        r_colour     <= n_colour;
        r_idx        <= n_idx;
        r_cmp_valid  <= n_cmp_valid;
        r_cmp_idx    <= n_cmp_idx;
        r_pend       <= n_pend;
        r_widx       <= n_widx;
        r_n          <= n_n;
        r_status     <= n_status;
        r_out        <= n_out;
        r_out_status <= n_out_status;
        r_out_total  <= n_out_total;
        r_out_ev     <= n_out_ev;
        r_out_last   <= n_out_last;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_total    = r_out_total;
    assign o_entry_valid    = r_out_ev;
    assign o_out_key_low    = r_out.key_low;
    assign o_out_key_high   = r_out.key_high;
    assign o_out_title_low  = r_out.title_low;
    assign o_out_title_high = r_out.title_high;
    assign o_out_colour     = r_out.colour;
    assign o_last           = r_out_last;

endmodule

// File: src/ket_checker.sv
`timescale 1ns / 1ps
// Port-level checks for keyed_entry_table, attached by the bind below.
// Depends on ket_pkg.
module ket_checker
    import ket_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [STATUS_W-1:0]        o_status,
    input logic [CNT_W-1:0]           o_entry_total,
    input logic                       o_entry_valid,
    input logic [LOW_W-1:0]           o_out_key_low,
    input logic [HIGH_W-1:0]          o_out_key_high,
    input logic [LOW_W-1:0]           o_out_title_low,
    input logic [HIGH_W-1:0]          o_out_title_high,
    input logic signed [COLOUR_W-1:0] o_out_colour,
    input logic                       o_last
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_valid |-> o_status == ST_OK && o_entry_total != '0)
        else $error("listed entry with bad status or empty table");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_last && o_out_key_low == '0 &&
        o_out_key_high == '0 && o_out_title_low == '0 &&
        o_out_title_high == '0 && o_out_colour == '0)
        else $error("empty result carries payload");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_entry_valid &&
        o_entry_total <= CNT_W'(TABLE_ENTRIES))
        else $error("non-final result is not a listed entry");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) &&
        $stable(o_out_key_low) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind keyed_entry_table ket_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .CNT_W(CNT_W)
) u_ket_checker (.*);
